// File: src/idalloc_pkg.sv
// ----------------------------------------------------------------------------
// idalloc_pkg
// Shared constants, types and codes for the dense-list ID allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package idalloc_pkg;

  localparam int MAX_IDS = 1024;
  localparam int ID_W    = $clog2(MAX_IDS);
  localparam int CNT_W   = ID_W + 1;

  typedef logic [ID_W-1:0]  id_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_ID    = 2'd1,
    ST_NOT_USED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC,
    S_FREE
  } state_t;

endpackage

`default_nettype wire

// File: src/id_allocator_dense_list_core.sv
// ----------------------------------------------------------------------------
// id_allocator_dense_list_core
// Sparse-set ID allocator: free stack, fresh counter, dense list, slot map.
//
// Usage:
//   Pulse start with in_command / in_free_id while busy is low; the command
//   beat is taken at that edge. Allocate pops the last freed ID, else takes
//   the next fresh ID, and appends it to the dense list. Free pushes the ID
//   on the free stack and moves the last dense entry into the vacated slot.
//   One result beat follows each command: out_valid is high for exactly one
//   cycle, after the command state and the result register, and the
//   receiver cannot stall it. Each command first reads the memories (free
//   stack top, in-use bit, slot map, dense tail) and then writes them back.
//   The next command may be accepted in the cycle the result is shown;
//   commands do not overlap, as one is taken only after the last writes back.
//   After reset the in-use memory is swept to zero, one entry per cycle,
//   over all 1024 entries; busy stays high during that sweep. Counters clear
//   at reset. out_used_count follows the count of IDs in use.
// ----------------------------------------------------------------------------
`default_nettype none

module id_allocator_dense_list_core (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        start,
  output logic                       busy,
  input  wire                        in_command,
  input  wire  [idalloc_pkg::ID_W-1:0]  in_free_id,
  output logic                       out_valid,
  output logic [1:0]                 out_status,
  output logic [idalloc_pkg::ID_W-1:0]  out_given_id,
  output logic [idalloc_pkg::ID_W-1:0]  out_given_slot,
  output logic                       out_moved_valid,
  output logic [idalloc_pkg::ID_W-1:0]  out_moved_id,
  output logic [idalloc_pkg::ID_W-1:0]  out_moved_slot,
  output logic [idalloc_pkg::CNT_W-1:0] out_used_count
);

  idalloc_pkg::state_t state_r, state_nxt;

  idalloc_pkg::id_t  fid_r;
  idalloc_pkg::id_t  clr_r, clr_nxt;
  idalloc_pkg::cnt_t depth_r, depth_nxt;
  idalloc_pkg::cnt_t fresh_r, fresh_nxt;
  idalloc_pkg::cnt_t used_r, used_nxt;
  logic              pop_r, ok_r;

  logic                   res_valid_r, res_valid_nxt;
  idalloc_pkg::status_t   res_status_r, res_status_nxt;
  idalloc_pkg::id_t       res_gid_r, res_gid_nxt;
  idalloc_pkg::id_t       res_gslot_r, res_gslot_nxt;
  logic                   res_mv_r, res_mv_nxt;
  idalloc_pkg::id_t       res_mid_r, res_mid_nxt;
  idalloc_pkg::id_t       res_mslot_r, res_mslot_nxt;

  idalloc_pkg::id_t fs_mem [idalloc_pkg::MAX_IDS];
  idalloc_pkg::id_t dl_mem [idalloc_pkg::MAX_IDS];
  idalloc_pkg::id_t sm_mem [idalloc_pkg::MAX_IDS];
  logic             iu_mem [idalloc_pkg::MAX_IDS];

  idalloc_pkg::id_t fs_rd_r, dl_rd_r, sm_rd_r;
  logic             iu_rd_r;

  logic             fs_we, dl_we, sm_we, iu_we, iu_wdata;
  idalloc_pkg::id_t fs_waddr, fs_wdata, dl_waddr, dl_wdata;
  idalloc_pkg::id_t sm_waddr, sm_wdata, iu_waddr;
  logic             fs_re, dl_re, sm_re, iu_re;
  idalloc_pkg::id_t fs_raddr, dl_raddr;

  logic             accept;
  logic             is_alloc;
  logic             pop_ok, fresh_ok;
  idalloc_pkg::id_t last_slot;
  idalloc_pkg::id_t alloc_id;
  logic             free_ok;

  assign accept    = start && !busy;
  assign is_alloc  = (idalloc_pkg::cmd_t'(in_command) == idalloc_pkg::CMD_ALLOC);
  assign pop_ok    = (depth_r != '0);
  assign fresh_ok  = (fresh_r < idalloc_pkg::cnt_t'(idalloc_pkg::MAX_IDS));
  assign last_slot = idalloc_pkg::id_t'(used_r - idalloc_pkg::cnt_t'(1));
  assign alloc_id  = pop_r ? fs_rd_r : idalloc_pkg::id_t'(fresh_r);
  assign free_ok   = iu_rd_r && (used_r != '0) &&
                     (depth_r < idalloc_pkg::cnt_t'(idalloc_pkg::MAX_IDS));

  // memories
  always_ff @(posedge clk) begin
    if (fs_we) fs_mem[fs_waddr] <= fs_wdata;
    if (fs_re) fs_rd_r <= fs_mem[fs_raddr];
  end

  always_ff @(posedge clk) begin
    if (dl_we) dl_mem[dl_waddr] <= dl_wdata;
    if (dl_re) dl_rd_r <= dl_mem[dl_raddr];
  end

  always_ff @(posedge clk) begin
    if (sm_we) sm_mem[sm_waddr] <= sm_wdata;
    if (sm_re) sm_rd_r <= sm_mem[in_free_id];
  end

  always_ff @(posedge clk) begin
    if (iu_we) iu_mem[iu_waddr] <= iu_wdata;
    if (iu_re) iu_rd_r <= iu_mem[in_free_id];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      idalloc_pkg::S_CLEAR: begin
        if (clr_r == '1) state_nxt = idalloc_pkg::S_IDLE;
      end
      idalloc_pkg::S_IDLE: begin
        if (accept) state_nxt = is_alloc ? idalloc_pkg::S_ALLOC : idalloc_pkg::S_FREE;
      end
      idalloc_pkg::S_ALLOC: state_nxt = idalloc_pkg::S_IDLE;
      idalloc_pkg::S_FREE:  state_nxt = idalloc_pkg::S_IDLE;
      default:              state_nxt = idalloc_pkg::S_IDLE;
    endcase
  end

  // outputs, memory control, counters
  always_comb begin
    busy      = (state_r != idalloc_pkg::S_IDLE);
    clr_nxt   = clr_r;
    depth_nxt = depth_r;
    fresh_nxt = fresh_r;
    used_nxt  = used_r;

    fs_re    = accept && is_alloc && pop_ok;
    fs_raddr = idalloc_pkg::id_t'(depth_r - idalloc_pkg::cnt_t'(1));
    dl_re    = accept && !is_alloc;
    dl_raddr = last_slot;
    sm_re    = accept && !is_alloc;
    iu_re    = accept && !is_alloc;

    fs_we = 1'b0; fs_waddr = idalloc_pkg::id_t'(depth_r); fs_wdata = fid_r;
    dl_we = 1'b0; dl_waddr = idalloc_pkg::id_t'(used_r);  dl_wdata = alloc_id;
    sm_we = 1'b0; sm_waddr = alloc_id; sm_wdata = idalloc_pkg::id_t'(used_r);
    iu_we = 1'b0; iu_waddr = alloc_id; iu_wdata = 1'b1;

    res_valid_nxt  = 1'b0;
    res_status_nxt = idalloc_pkg::ST_OK;
    res_gid_nxt    = '0;
    res_gslot_nxt  = '0;
    res_mv_nxt     = 1'b0;
    res_mid_nxt    = '0;
    res_mslot_nxt  = '0;

    unique case (state_r)
      idalloc_pkg::S_CLEAR: begin
        iu_we    = 1'b1;
        iu_waddr = clr_r;
        iu_wdata = 1'b0;
        clr_nxt  = clr_r + idalloc_pkg::id_t'(1);
      end
      idalloc_pkg::S_IDLE: begin
      end
      idalloc_pkg::S_ALLOC: begin
        res_valid_nxt = 1'b1;
        if (ok_r) begin
          dl_we         = 1'b1;
          sm_we         = 1'b1;
          iu_we         = 1'b1;
          res_gid_nxt   = alloc_id;
          res_gslot_nxt = idalloc_pkg::id_t'(used_r);
          used_nxt      = used_r + idalloc_pkg::cnt_t'(1);
          if (pop_r) depth_nxt = depth_r - idalloc_pkg::cnt_t'(1);
          else       fresh_nxt = fresh_r + idalloc_pkg::cnt_t'(1);
        end else begin
          res_status_nxt = idalloc_pkg::ST_NO_ID;
        end
      end
      idalloc_pkg::S_FREE: begin
        res_valid_nxt = 1'b1;
        if (free_ok) begin
          fs_we     = 1'b1;
          iu_we     = 1'b1;
          iu_waddr  = fid_r;
          iu_wdata  = 1'b0;
          depth_nxt = depth_r + idalloc_pkg::cnt_t'(1);
          used_nxt  = used_r - idalloc_pkg::cnt_t'(1);
          if (sm_rd_r != last_slot) begin
            dl_we         = 1'b1;
            dl_waddr      = sm_rd_r;
            dl_wdata      = dl_rd_r;
            sm_we         = 1'b1;
            sm_waddr      = dl_rd_r;
            sm_wdata      = sm_rd_r;
            res_mv_nxt    = 1'b1;
            res_mid_nxt   = dl_rd_r;
            res_mslot_nxt = sm_rd_r;
          end
        end else begin
          res_status_nxt = idalloc_pkg::ST_NOT_USED;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= idalloc_pkg::S_CLEAR;
      clr_r       <= '0;
      depth_r     <= '0;
      fresh_r     <= '0;
      used_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      depth_r     <= depth_nxt;
      fresh_r     <= fresh_nxt;
      used_r      <= used_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fid_r <= in_free_id;
      pop_r <= pop_ok;
      ok_r  <= (pop_ok || fresh_ok) &&
               (used_r < idalloc_pkg::cnt_t'(idalloc_pkg::MAX_IDS));
    end
    if (res_valid_nxt) begin
      res_status_r <= res_status_nxt;
      res_gid_r    <= res_gid_nxt;
      res_gslot_r  <= res_gslot_nxt;
      res_mv_r     <= res_mv_nxt;
      res_mid_r    <= res_mid_nxt;
      res_mslot_r  <= res_mslot_nxt;
    end
  end

  assign out_valid       = res_valid_r;
  assign out_status      = res_status_r;
  assign out_given_id    = res_gid_r;
  assign out_given_slot  = res_gslot_r;
  assign out_moved_valid = res_mv_r;
  assign out_moved_id    = res_mid_r;
  assign out_moved_slot  = res_mslot_r;
  assign out_used_count  = used_r;

  a_counts_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (used_r + depth_r) == fresh_r)
    else $error("used plus free stack depth differs from fresh count");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##2 out_valid)
    else $error("command without result two cycles later");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == idalloc_pkg::S_ALLOC ||
                   $past(state_r) == idalloc_pkg::S_FREE))
    else $error("result beat outside a command");

  a_exhaust_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == idalloc_pkg::ST_NO_ID) |->
      (out_used_count == idalloc_pkg::cnt_t'(idalloc_pkg::MAX_IDS)))
    else $error("exhaustion reported with IDs left");

  a_move_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_moved_valid) |-> (out_status == idalloc_pkg::ST_OK))
    else $error("move reported on a rejected free");

endmodule

`default_nettype wire
